// File: rtl/core/fast_order_message_encoder_defines.svh
// Assertion macros shared by the FAST order message encoder RTL.
`ifndef FAST_ORDER_MESSAGE_ENCODER_DEFINES_SVH
`define FAST_ORDER_MESSAGE_ENCODER_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define FOME_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("fome: same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define FOME_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("fome: next-cycle check failed");

`endif

// File: rtl/core/fome_pkg.sv
// Package with the constants and types of the FAST order message encoder.
`timescale 1ns / 1ps
`default_nettype none
package fome_pkg;

    typedef logic [7:0] t_byte;

    localparam int PACK_BYTES_DEF = 8;
    localparam int GROUP_W        = 7;
    localparam int HDR_BYTES      = 4;

    localparam t_byte STOP_FLAG = 8'h80;
    localparam t_byte HDR_PMAP  = 8'hFC;
    localparam t_byte HDR_TID   = 8'h81;
    localparam t_byte HDR_EXP   = 8'h80;
    localparam t_byte HDR_PRICE = 8'h81;

    localparam int SIZE_W     = 8;
    localparam int IDENT_W    = 32;
    localparam int KIND_W     = 3;
    localparam int KIND_ENC_W = 2;

    localparam int SIZE_GROUPS  = (SIZE_W + GROUP_W - 1) / GROUP_W;
    localparam int IDENT_GROUPS = (IDENT_W + GROUP_W - 1) / GROUP_W;
    localparam int BODY_BYTES   = SIZE_GROUPS + IDENT_GROUPS;

    localparam int SIZE_LEN_W  = $clog2(SIZE_GROUPS + 1);
    localparam int IDENT_LEN_W = $clog2(IDENT_GROUPS + 1);
    localparam int BODY_LEN_W  = $clog2(BODY_BYTES + 1);

endpackage
`default_nettype wire

// File: rtl/core/fast_order_message_encoder.sv
// An accepted request passes through the r1, r2 and r3 stage registers to o_valid, and waits there while i_stall holds.
// Throughput: one order per cycle while i_stall is low; the three stage registers each hold one order.
// Stage one encodes the fields, stage two joins size and id, stage three builds the words.
// A stall holds only the stages that are full, so empty stages keep taking requests.
// Reset clears the stage valid bits; payload registers are not reset.
`timescale 1ns / 1ps
`default_nettype none
`include "fast_order_message_encoder_defines.svh"
module fast_order_message_encoder #(
    parameter int PACK_BYTES = fome_pkg::PACK_BYTES_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_stall,
    input  wire logic [fome_pkg::SIZE_W-1:0]    i_order_size,
    input  wire logic [fome_pkg::IDENT_W-1:0]   i_order_ident,
    input  wire logic [fome_pkg::KIND_W-1:0]    i_order_kind,
    output logic                                o_valid,
    input  wire logic                           i_stall,
    output logic [PACK_BYTES*8-1:0]             o_low_packet,
    output logic [PACK_BYTES*8-1:0]             o_high_packet
);
    import fome_pkg::*;

    localparam int MSG_BYTES = 2 * PACK_BYTES;
    localparam int BCMP_W    = BODY_LEN_W + 1;

    logic en1, en2, en3;

    t_byte [SIZE_GROUPS-1:0]    n1_size_bytes;
    logic [SIZE_LEN_W-1:0]      n1_size_len;
    t_byte [IDENT_GROUPS-1:0]   n1_id_bytes;
    logic [IDENT_LEN_W-1:0]     n1_id_len;

    logic                       r1_valid;
    t_byte [SIZE_GROUPS-1:0]    r1_size_bytes;
    logic [SIZE_LEN_W-1:0]      r1_size_len;
    t_byte [IDENT_GROUPS-1:0]   r1_id_bytes;
    logic [IDENT_LEN_W-1:0]     r1_id_len;
    logic [KIND_ENC_W-1:0]      r1_kind;

    t_byte [BODY_BYTES-1:0]     n2_body;
    logic [BODY_LEN_W-1:0]      n2_body_len;

    logic                       r2_valid;
    t_byte [BODY_BYTES-1:0]     r2_body;
    logic [BODY_LEN_W-1:0]      r2_body_len;
    logic [KIND_ENC_W-1:0]      r2_kind;

    t_byte [MSG_BYTES-1:0]      n3_msg;

    logic                       r3_valid;
    t_byte [MSG_BYTES-1:0]      r3_msg;

    assign en3     = !r3_valid || !i_stall;
    assign en2     = !r2_valid || en3;
    assign en1     = !r1_valid || en2;
    assign o_stall = !en1;

    fome_stop_enc #(
        .VAL_W  (SIZE_W)
    ) u_size_enc (
        .i_value (i_order_size),
        .o_bytes (n1_size_bytes),
        .o_len   (n1_size_len)
    );

    fome_stop_enc #(
        .VAL_W  (IDENT_W)
    ) u_ident_enc (
        .i_value (i_order_ident),
        .o_bytes (n1_id_bytes),
        .o_len   (n1_id_len)
    );

    always_comb begin
        n2_body = '0;
        for (int k = 0; k < SIZE_GROUPS; k++) begin
            if (BCMP_W'(k) < BCMP_W'(r1_size_len)) begin
                n2_body[k] = r1_size_bytes[k];
            end
        end
        for (int k = 0; k < IDENT_GROUPS; k++) begin
            for (int j = 0; j < BODY_BYTES; j++) begin
                if (BCMP_W'(k) < BCMP_W'(r1_id_len) &&
                    BCMP_W'(j) == BCMP_W'(r1_size_len) + BCMP_W'(k)) begin
                    n2_body[j] = r1_id_bytes[k];
                end
            end
        end
        n2_body_len = BODY_LEN_W'(r1_size_len) + BODY_LEN_W'(r1_id_len);
    end

    always_comb begin
        n3_msg    = '0;
        n3_msg[0] = HDR_PMAP;
        n3_msg[1] = HDR_TID;
        n3_msg[2] = HDR_EXP;
        n3_msg[3] = HDR_PRICE;
        for (int j = 0; j < BODY_BYTES; j++) begin
            if (BCMP_W'(j) < BCMP_W'(r2_body_len)) begin
                n3_msg[HDR_BYTES + j] = r2_body[j];
            end
        end
        for (int j = 0; j <= BODY_BYTES; j++) begin
            if (BCMP_W'(j) == BCMP_W'(r2_body_len)) begin
                n3_msg[HDR_BYTES + j] = STOP_FLAG | 8'(r2_kind);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else begin
            if (en1) begin
                r1_valid <= i_valid;
            end
            if (en2) begin
                r2_valid <= r1_valid;
            end
            if (en3) begin
                r3_valid <= r2_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_size_bytes <= n1_size_bytes;
            r1_size_len   <= n1_size_len;
            r1_id_bytes   <= n1_id_bytes;
            r1_id_len     <= n1_id_len;
            r1_kind       <= i_order_kind[KIND_ENC_W-1:0];
        end
        if (en2) begin
            r2_body     <= n2_body;
            r2_body_len <= n2_body_len;
            r2_kind     <= r1_kind;
        end
        if (en3) begin
            r3_msg <= n3_msg;
        end
    end

    assign o_valid       = r3_valid;
    assign o_low_packet  = r3_msg[PACK_BYTES-1:0];
    assign o_high_packet = r3_msg[MSG_BYTES-1:PACK_BYTES];

    `FOME_ASSERT_NOW(a_header_bytes, o_valid, o_low_packet[31:0] == 32'h818081FC)
    `FOME_ASSERT_NOW(a_three_stop_bits, o_valid,
        $countones({o_low_packet[39], o_low_packet[47], o_low_packet[55], o_low_packet[63],
                    o_high_packet[7], o_high_packet[15], o_high_packet[23],
                    o_high_packet[31]}) == 3)
    `FOME_ASSERT_NOW(a_tail_padding, o_valid, o_high_packet[63:32] == 32'h0)
    `FOME_ASSERT_NEXT(a_held_result, r3_valid && i_stall, r3_valid && $stable(r3_msg))

endmodule
`default_nettype wire

// File: rtl/core/fome_stop_enc.sv
// Stop-bit encoder for one unsigned field, bytes left aligned with their count.
`timescale 1ns / 1ps
`default_nettype none
module fome_stop_enc #(
    parameter int VAL_W  = fome_pkg::IDENT_W,
    parameter int GROUPS = (VAL_W + fome_pkg::GROUP_W - 1) / fome_pkg::GROUP_W,
    parameter int LEN_W  = $clog2(GROUPS + 1)
) (
    input  wire logic [VAL_W-1:0]               i_value,
    output fome_pkg::t_byte [GROUPS-1:0]        o_bytes,
    output logic [LEN_W-1:0]                    o_len
);
    import fome_pkg::*;

    localparam int PAD_W = GROUPS * GROUP_W;
    localparam int CMP_W = LEN_W + 1;

    logic [PAD_W-1:0]           pad;
    t_byte [GROUPS-1:0]         full;
    logic [LEN_W-1:0]           lead_zero;

    assign pad = PAD_W'(i_value);

    always_comb begin
        for (int k = 0; k < GROUPS; k++) begin
            full[k] = {1'b0, pad[(GROUPS - 1 - k) * GROUP_W +: GROUP_W]};
        end
        full[GROUPS-1] = full[GROUPS-1] | STOP_FLAG;
    end

    always_comb begin
        logic found;
        found     = 1'b0;
        lead_zero = '0;
        for (int k = 0; k < GROUPS - 1; k++) begin
            if (!found && full[k] == '0) begin
                lead_zero = lead_zero + LEN_W'(1);
            end else begin
                found = 1'b1;
            end
        end
    end

    assign o_len = LEN_W'(GROUPS) - lead_zero;

    always_comb begin
        for (int j = 0; j < GROUPS; j++) begin
            o_bytes[j] = '0;
            for (int k = 0; k < GROUPS; k++) begin
                if (CMP_W'(k) == CMP_W'(j) + CMP_W'(lead_zero)) begin
                    o_bytes[j] = full[k];
                end
            end
        end
    end

endmodule
`default_nettype wire

// File: tb/fast_order_message_encoder_tb.sv
// Self-checking testbench for the FAST order message encoder under random flow control.
`timescale 1ns / 1ps
`default_nettype none
module fast_order_message_encoder_tb;
    import fome_pkg::*;

    localparam int WORD_W = PACK_BYTES_DEF * 8;

    typedef struct {
        logic [SIZE_W-1:0]  size;
        logic [IDENT_W-1:0] ident;
        logic [KIND_W-1:0]  kind;
        logic [WORD_W-1:0]  low;
        logic [WORD_W-1:0]  high;
    } t_message;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [SIZE_W-1:0]  i_order_size = '0;
    logic [IDENT_W-1:0] i_order_ident = '0;
    logic [KIND_W-1:0]  i_order_kind = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic [WORD_W-1:0]  o_low_packet;
    logic [WORD_W-1:0]  o_high_packet;

    t_message expected_messages[$];
    int       mismatch_count = 0;
    bit       quiet = 1'b0;
    bit       hold_request = 1'b0;
    int       hold_left = 0;

    fast_order_message_encoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_order_size  (i_order_size),
        .i_order_ident (i_order_ident),
        .i_order_kind  (i_order_kind),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_low_packet  (o_low_packet),
        .o_high_packet (o_high_packet)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // Header bytes, then size, id and type as stop-bit integers, zero padded.
    function automatic logic [2*WORD_W-1:0] encode_order(input logic [SIZE_W-1:0] size,
                                                         input logic [IDENT_W-1:0] ident,
                                                         input logic [KIND_W-1:0] kind);
        logic [34:0]         fields [3];
        logic [2*WORD_W-1:0] message;
        t_byte               group;
        int                  count;
        bit                  started;
        message = '0;
        message[7:0]   = HDR_PMAP;
        message[15:8]  = HDR_TID;
        message[23:16] = HDR_EXP;
        message[31:24] = HDR_PRICE;
        count = HDR_BYTES;
        fields[0] = 35'(size);
        fields[1] = 35'(ident);
        fields[2] = 35'(kind[KIND_ENC_W-1:0]);
        for (int f = 0; f < 3; f++) begin
            started = 1'b0;
            for (int g = 4; g >= 0; g--) begin
                group = {1'b0, fields[f][g*GROUP_W +: GROUP_W]};
                if (group != 8'h00 || started || g == 0) begin
                    if (g == 0) begin
                        group = group | STOP_FLAG;
                    end
                    message[count*8 +: 8] = group;
                    count++;
                    started = 1'b1;
                end
            end
        end
        return message;
    endfunction

    function automatic void note_failure(input string text);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("%0t: %s", $time, text);
        end
    endfunction

    function automatic logic [IDENT_W-1:0] random_ident();
        int bits;
        bits = $urandom_range(0, IDENT_W);
        return (bits == 0) ? '0 : IDENT_W'($urandom) >> (IDENT_W - bits);
    endfunction

    function automatic logic [SIZE_W-1:0] random_size();
        return ($urandom_range(0, 1) == 0) ? SIZE_W'($urandom_range(0, 127))
                                           : SIZE_W'($urandom_range(0, 255));
    endfunction

    // Receiver: checks each accepted message and drives the result stall.
    always @(posedge i_clk) begin : receive_messages
        t_message expected;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_messages.size() == 0) begin
                note_failure($sformatf("unexpected message low=%h high=%h",
                                       o_low_packet, o_high_packet));
            end else begin
                expected = expected_messages.pop_front();
                if (o_low_packet !== expected.low) begin
                    note_failure($sformatf("size=%h id=%h type=%h low expected %h got %h",
                                           expected.size, expected.ident, expected.kind,
                                           expected.low, o_low_packet));
                end
                if (o_high_packet !== expected.high) begin
                    note_failure($sformatf("size=%h id=%h type=%h high expected %h got %h",
                                           expected.size, expected.ident, expected.kind,
                                           expected.high, o_high_packet));
                end
            end
        end
        if (hold_request) begin
            hold_request = 1'b0;
            hold_left = 120;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= !quiet && ($urandom_range(0, 99) < 25);
        end
    end

    task automatic send_order(input logic [SIZE_W-1:0] size, input logic [IDENT_W-1:0] ident,
                              input logic [KIND_W-1:0] kind);
        t_message            entry;
        logic [2*WORD_W-1:0] message;
        while (!quiet && $urandom_range(0, 99) < 25) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_order_size  <= size;
        i_order_ident <= ident;
        i_order_kind  <= kind;
        do @(posedge i_clk); while (o_stall);
        message = encode_order(size, ident, kind);
        entry.size  = size;
        entry.ident = ident;
        entry.kind  = kind;
        entry.low   = message[WORD_W-1:0];
        entry.high  = message[2*WORD_W-1:WORD_W];
        expected_messages.push_back(entry);
    endtask

    task automatic wait_drained();
        while (expected_messages.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Group boundaries of every field, zero values and all type codes.
    task automatic test_field_extremes();
        logic [SIZE_W-1:0]  sizes [5];
        logic [IDENT_W-1:0] idents [12];
        sizes  = '{8'd0, 8'd1, 8'd127, 8'd128, 8'd255};
        idents = '{32'd0, 32'd1, 32'd127, 32'd128, 32'd16383, 32'd16384, 32'd2097151,
                   32'd2097152, 32'd268435455, 32'd268435456, 32'h8000_0000, 32'hFFFF_FFFF};
        for (int i = 0; i < 12; i++) begin
            send_order(sizes[i % 5], idents[i], KIND_W'(i));
        end
        for (int k = 0; k < 8; k++) begin
            send_order(sizes[(k + 2) % 5], idents[11 - k], KIND_W'(k));
        end
    endtask

    task automatic test_random_orders(input int count);
        for (int i = 0; i < count; i++) begin
            send_order(random_size(), random_ident(), KIND_W'($urandom_range(0, 7)));
        end
    endtask

    task automatic test_back_to_back();
        quiet = 1'b1;
        test_random_orders(60);
        quiet = 1'b0;
    endtask

    // The receiver holds off while requests keep coming, so the pipeline fills up.
    task automatic test_receiver_hold();
        hold_request = 1'b1;
        test_random_orders(40);
    endtask

    task automatic test_sender_pause();
        i_valid <= 1'b0;
        wait_drained();
        test_random_orders(20);
    endtask

    initial begin
        i_rst_n <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_field_extremes();
        test_random_orders(150);
        test_back_to_back();
        test_receiver_hold();
        test_sender_pause();
        test_random_orders(160);
        i_valid <= 1'b0;
        wait_drained();
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0 && expected_messages.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
`default_nettype wire
